// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication, off while rst is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Clocked next-cycle implication, off while rst is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/pipw_pkg.sv -----
// Package: widths, types and codes of the point-in-polygon winding block.
`default_nettype none

package pipw_pkg;

  localparam int COORD_BITS = 16;
  localparam int ACC_BITS   = 14;
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;
  typedef logic [1:0]                   quad_t;

  // Quadrants around the query point, counterclockwise from +x/+y.
  localparam quad_t QUAD_NE = 2'd0;
  localparam quad_t QUAD_NW = 2'd1;
  localparam quad_t QUAD_SW = 2'd2;
  localparam quad_t QUAD_SE = 2'd3;

  // Quadrant change along one edge, modulo four.
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_CCW  = 2'd1,
    STEP_DIAG = 2'd2,
    STEP_CW   = 2'd3
  } quad_step_t;

  // Register select, paddr[2].
  localparam logic REG_QUERY_X = 1'b0;
  localparam logic REG_QUERY_Y = 1'b1;

  localparam acc_t ACC_MAX = acc_t'((1 << (ACC_BITS - 1)) - 1);
  localparam acc_t ACC_MIN = acc_t'(-(1 << (ACC_BITS - 1)));

endpackage

`default_nettype wire

// ----- rtl/pipw_if.sv -----
// Valid/ready channel interfaces for vertices and results.
`default_nettype none

interface pipw_vertex_if;
  logic                valid;
  logic                ready;
  pipw_pkg::coord_t    vertex_x;
  pipw_pkg::coord_t    vertex_y;
  logic                last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

interface pipw_result_if;
  logic                valid;
  logic                ready;
  logic                inside_res;
  pipw_pkg::acc_t      winding_quarters;

  modport source (output valid, output inside_res, output winding_quarters, input ready);
  modport sink   (input valid, input inside_res, input winding_quarters, output ready);
endinterface

`default_nettype wire

// ----- rtl/point_in_polygon_quadrant_winding.sv -----
// Output: a result becomes valid once the last vertex has passed the stage 1, stage 2 and result registers.
// Throughput: one vertex per cycle; stages advance while the result register is free.
// Pipeline: input stage (quadrant codes, four exact products), sum/sign stage,
// then the saturating accumulator feeding the result register.
// Reset: synchronous; clears query, polygon state, accumulator and all valid bits.
`default_nettype none

`include "assert_macros.svh"

module point_in_polygon_quadrant_winding (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pipw_pkg::PADDR_BITS-1:0]  paddr,
  input  wire logic [pipw_pkg::PDATA_BITS-1:0]  pwdata,
  output logic      [pipw_pkg::PDATA_BITS-1:0]  prdata,
  output logic                                  pready,
  pipw_vertex_if.sink                           vertex,
  pipw_result_if.source                         result
);

  localparam int DIFF_BITS = pipw_pkg::COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;

  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;
  typedef logic signed [2:0]           delta_t;

  typedef struct packed {
    pipw_pkg::coord_t x;
    pipw_pkg::coord_t y;
    pipw_pkg::coord_t px;
    pipw_pkg::coord_t py;
    pipw_pkg::coord_t fx;
    pipw_pkg::coord_t fy;
    pipw_pkg::quad_t  q;
    pipw_pkg::quad_t  pq;
    logic             new_poly;
    logic             last;
  } s1_t;

  typedef struct packed {
    prod_t                a1;
    prod_t                b1;
    prod_t                a2;
    prod_t                b2;
    pipw_pkg::quad_step_t step1;
    pipw_pkg::quad_step_t step2;
    logic                 new_poly;
    logic                 last;
  } s2_t;

  function automatic pipw_pkg::quad_t quad_of(pipw_pkg::coord_t x, pipw_pkg::coord_t y,
                                              pipw_pkg::coord_t qx, pipw_pkg::coord_t qy);
    pipw_pkg::quad_t q;
    if (x < qx) begin
      q = (y < qy) ? pipw_pkg::QUAD_SW : pipw_pkg::QUAD_NW;
    end else begin
      q = (y < qy) ? pipw_pkg::QUAD_SE : pipw_pkg::QUAD_NE;
    end
    return q;
  endfunction

  function automatic delta_t step_delta(pipw_pkg::quad_step_t st, logic neg);
    delta_t d;
    case (st)
      pipw_pkg::STEP_CCW:  d = 3'sd1;
      pipw_pkg::STEP_CW:   d = -3'sd1;
      pipw_pkg::STEP_DIAG: d = neg ? -3'sd2 : 3'sd2;
      default:             d = 3'sd0;
    endcase
    return d;
  endfunction

  function automatic pipw_pkg::acc_t sat_add(pipw_pkg::acc_t a, delta_t d);
    logic signed [pipw_pkg::ACC_BITS:0] s;
    pipw_pkg::acc_t r;
    s = (pipw_pkg::ACC_BITS + 1)'(a) + (pipw_pkg::ACC_BITS + 1)'(d);
    if (s > (pipw_pkg::ACC_BITS + 1)'(pipw_pkg::ACC_MAX)) begin
      r = pipw_pkg::ACC_MAX;
    end else if (s < (pipw_pkg::ACC_BITS + 1)'(pipw_pkg::ACC_MIN)) begin
      r = pipw_pkg::ACC_MIN;
    end else begin
      r = s[pipw_pkg::ACC_BITS-1:0];
    end
    return r;
  endfunction

  // Configuration
  pipw_pkg::coord_t query_x;
  pipw_pkg::coord_t query_y;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == pipw_pkg::REG_QUERY_Y) ? pipw_pkg::PDATA_BITS'(query_y)
                                                         : pipw_pkg::PDATA_BITS'(query_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == pipw_pkg::REG_QUERY_X) begin
        query_x <= pwdata[pipw_pkg::COORD_BITS-1:0];
      end else begin
        query_y <= pwdata[pipw_pkg::COORD_BITS-1:0];
      end
    end
  end

  // Polygon state
  pipw_pkg::coord_t first_vx;
  pipw_pkg::coord_t first_vy;
  pipw_pkg::coord_t prev_vx;
  pipw_pkg::coord_t prev_vy;
  pipw_pkg::quad_t  prev_quadrant;
  logic             seen_first;

  // Pipeline
  s1_t              s1;
  s1_t              s1_next;
  logic             s1_valid;
  s2_t              s2;
  s2_t              s2_next;
  logic             s2_valid;
  pipw_pkg::acc_t   quarter_acc;
  pipw_pkg::acc_t   acc_next;
  logic             out_valid;
  logic             inside_res;
  pipw_pkg::acc_t   winding_quarters;

  logic             out_free;
  logic             s2_adv;
  logic             s1_adv;
  logic             in_xfer;
  pipw_pkg::quad_t  q_in;

  assign out_free = !out_valid || result.ready;
  assign s2_adv   = s2_valid && out_free;
  assign s1_adv   = s1_valid && (!s2_valid || out_free);
  assign vertex.ready = !s1_valid || s1_adv;
  assign in_xfer  = vertex.valid && vertex.ready;

  assign q_in = quad_of(vertex.vertex_x, vertex.vertex_y, query_x, query_y);

  always_comb begin
    s1_next.x        = vertex.vertex_x;
    s1_next.y        = vertex.vertex_y;
    s1_next.px       = prev_vx;
    s1_next.py       = prev_vy;
    s1_next.fx       = seen_first ? first_vx : vertex.vertex_x;
    s1_next.fy       = seen_first ? first_vy : vertex.vertex_y;
    s1_next.q        = q_in;
    s1_next.pq       = prev_quadrant;
    s1_next.new_poly = !seen_first;
    s1_next.last     = vertex.last_vertex;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_vx      <= '0;
      first_vy      <= '0;
      prev_vx       <= '0;
      prev_vy       <= '0;
      prev_quadrant <= pipw_pkg::QUAD_NE;
      seen_first    <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (!seen_first) begin
          first_vx <= vertex.vertex_x;
          first_vy <= vertex.vertex_y;
        end
        prev_vx       <= vertex.vertex_x;
        prev_vy       <= vertex.vertex_y;
        prev_quadrant <= q_in;
        seen_first    <= !vertex.last_vertex;
      end
      if (vertex.ready) begin
        s1_valid <= vertex.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1 <= s1_next;
    end
  end

  // Stage 1: offsets from the query point and the cross-product terms.
  diff_t           dx_cur;
  diff_t           dy_cur;
  diff_t           dx_prev;
  diff_t           dy_prev;
  diff_t           dx_first;
  diff_t           dy_first;
  pipw_pkg::quad_t q_first;

  always_comb begin
    dx_cur   = DIFF_BITS'(s1.x)  - DIFF_BITS'(query_x);
    dy_cur   = DIFF_BITS'(s1.y)  - DIFF_BITS'(query_y);
    dx_prev  = DIFF_BITS'(s1.px) - DIFF_BITS'(query_x);
    dy_prev  = DIFF_BITS'(s1.py) - DIFF_BITS'(query_y);
    dx_first = DIFF_BITS'(s1.fx) - DIFF_BITS'(query_x);
    dy_first = DIFF_BITS'(s1.fy) - DIFF_BITS'(query_y);
    q_first  = quad_of(s1.fx, s1.fy, query_x, query_y);

    s2_next.a1       = PROD_BITS'(dy_cur) * PROD_BITS'(dx_prev);
    s2_next.b1       = -(PROD_BITS'(dx_cur) * PROD_BITS'(dy_prev));
    s2_next.a2       = PROD_BITS'(dy_first) * PROD_BITS'(dx_cur);
    s2_next.b2       = -(PROD_BITS'(dx_first) * PROD_BITS'(dy_cur));
    s2_next.step1    = s1.new_poly ? pipw_pkg::STEP_NONE : pipw_pkg::quad_step_t'(s1.q - s1.pq);
    s2_next.step2    = s1.last ? pipw_pkg::quad_step_t'(q_first - s1.q) : pipw_pkg::STEP_NONE;
    s2_next.new_poly = s1.new_poly;
    s2_next.last     = s1.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || out_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2 <= s2_next;
    end
  end

  // Stage 2: sign of each cross product, then two saturating updates.
  sum_t           sum1;
  sum_t           sum2;
  pipw_pkg::acc_t acc_base;
  pipw_pkg::acc_t acc_mid;

  always_comb begin
    sum1     = SUM_BITS'(s2.a1) + SUM_BITS'(s2.b1);
    sum2     = SUM_BITS'(s2.a2) + SUM_BITS'(s2.b2);
    acc_base = s2.new_poly ? '0 : quarter_acc;
    acc_mid  = sat_add(acc_base, step_delta(s2.step1, sum1[SUM_BITS-1]));
    acc_next = sat_add(acc_mid, step_delta(s2.step2, sum2[SUM_BITS-1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_acc <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (s2_adv) begin
        quarter_acc <= acc_next;
      end
      if (out_free) begin
        out_valid <= s2_valid && s2.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2.last) begin
      winding_quarters <= acc_next;
      inside_res       <= (acc_next >= pipw_pkg::acc_t'(2)) ||
                          (acc_next <= pipw_pkg::acc_t'(-2));
    end
  end

  assign result.valid            = out_valid;
  assign result.inside_res       = inside_res;
  assign result.winding_quarters = winding_quarters;

  `ASSERT_CLK(a_result_from_last,
    !(out_valid && !$past(out_valid) && !$past(rst)) || $past(s2_valid && s2.last),
    "result appeared without a closing vertex in the last stage")
  `ASSERT_NEXT(a_last_ends_polygon, in_xfer && vertex.last_vertex, !seen_first,
    "polygon state not cleared after the last vertex")
  `ASSERT_NEXT(a_stage2_holds, s2_valid && !out_free,
    s2_valid && $stable(s2.step1) && $stable(s2.step2) && $stable(s2.last),
    "stage 2 changed while the result register was stalled")

endmodule

`default_nettype wire
